// ===== rtl/core/ima_pkg.sv =====
// Shared constants, register codes and the step-size table of the IMA ADPCM codec.
package ima_pkg;

  localparam int unsigned IDX_MAX = 88;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned PCM_W   = 16;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [PCM_W+1:0] PCM_MIN = -18'sd32768;
  localparam logic signed [PCM_W+1:0] PCM_MAX = 18'sd32767;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_PRED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_IDX  = 2'd2;

  // Code bit positions
  localparam int unsigned CODE_SIGN   = 3;
  localparam int unsigned CODE_MAG_HI = 2;

  function automatic logic [STEP_W-1:0] step_rom(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Index change for code bits 2..0
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/ima_if.sv =====
// Stream and configuration channel interfaces of the IMA ADPCM codec.
interface ima_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [15:0] pcm_in;
  logic [3:0]         code_in;

  modport source (output valid, output restart, output pcm_in, output code_in, input ready);
  modport sink   (input valid, input restart, input pcm_in, input code_in, output ready);
endinterface

interface ima_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         code_out;
  logic signed [15:0] pcm_out;
  logic [6:0]         step_index_out;

  modport source (output valid, output code_out, output pcm_out, output step_index_out,
                  input ready);
  modport sink   (input valid, input code_out, input pcm_out, input step_index_out,
                  output ready);
endinterface

interface ima_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ima_adpcm_codec.sv =====
// IMA ADPCM 4-bit codec, one channel: input stage, codec datapath, result register.
//
// Usage:
//   in_ch   carries one item per sample: restart, pcm_in (encode) and code_in (decode).
//   out_ch  returns one item per input item: code_out, pcm_out, step_index_out.
//   cfg_ch  writes encode_mode (index 0), the restart predictor (1) and the
//           restart step index (2); it is always ready. Write it only while idle.
// Timing: an accepted item is held in the input register, then passes through the
//   codec datapath into the result register and is presented on out_ch from there.
//   Throughput: one item per cycle unless out_ch stalls; the predictor and step index
//   recurrence is a single pass of shift-add-compare and clamp logic between those
//   two registers.
// Restart: an item with restart set first reloads the predictor and the step index
//   (clamped to 88) from the initial-value registers.
// Reset (rst, synchronous): both stages empty, predictor and index zero, registers
//   back to decode mode with zero initial values.
// Stall: when out_ch.ready is low the result holds; the input register still takes
//   one more item, after which in_ch.ready drops until the result is taken.
module ima_adpcm_codec (
  input  logic    clk,
  input  logic    rst,
  ima_in_if.sink  in_ch,
  ima_out_if.source out_ch,
  ima_cfg_if.sink cfg_ch
);
  import ima_pkg::*;

  // Configuration registers
  logic                    encode_mode;
  logic signed [PCM_W-1:0] restart_pred;
  logic [7:0]              restart_idx;

  // Adaptive state
  logic signed [PCM_W-1:0] predictor;
  logic [IDX_W-1:0]        index;

  // Input register
  logic                    s1_valid;
  logic                    s1_restart;
  logic signed [PCM_W-1:0] s1_pcm;
  logic [CODE_W-1:0]       s1_code;

  // Result register
  logic                    out_valid;
  logic [CODE_W-1:0]       out_code;
  logic signed [PCM_W-1:0] out_pcm;
  logic [IDX_W-1:0]        out_index;

  logic s1_adv;
  logic in_acc;

  assign s1_adv = s1_valid && (!out_valid || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid || s1_adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid;
  assign out_ch.code_out       = out_code;
  assign out_ch.pcm_out        = out_pcm;
  assign out_ch.step_index_out = out_index;

  // Datapath
  logic signed [PCM_W-1:0] pred_cur;
  logic [IDX_W-1:0]        idx_cur;
  logic [STEP_W-1:0]       step;
  logic signed [PCM_W:0]   diff;
  logic [PCM_W:0]          mag0;
  logic [PCM_W:0]          mag1;
  logic [PCM_W:0]          mag2;
  logic [PCM_W:0]          st0;
  logic [PCM_W:0]          st1;
  logic [PCM_W:0]          st2;
  logic [CODE_W-1:0]       code;
  logic [PCM_W:0]          vpdiff;
  logic signed [PCM_W+1:0] pred_sum;
  logic signed [PCM_W-1:0] pred_next;
  logic signed [IDX_W+1:0] idx_sum;
  logic [IDX_W-1:0]        idx_next;

  always_comb begin
    if (s1_restart) begin
      pred_cur = restart_pred;
      idx_cur  = (restart_idx > 8'(IDX_MAX)) ? IDX_W'(IDX_MAX)
                                            : restart_idx[IDX_W-1:0];
    end else begin
      pred_cur = predictor;
      idx_cur  = index;
    end

    step = step_rom(idx_cur);
    st0  = {{(PCM_W+1-STEP_W){1'b0}}, step};
    st1  = st0 >> 1;
    st2  = st0 >> 2;

    diff = {s1_pcm[PCM_W-1], s1_pcm} - {pred_cur[PCM_W-1], pred_cur};
    mag0 = diff[PCM_W] ? (PCM_W+1)'(-diff) : diff;
    mag1 = mag0;
    mag2 = mag0;
    code = '0;

    if (encode_mode) begin
      code[CODE_SIGN] = diff[PCM_W];
      if (mag0 >= st0) begin
        code[CODE_MAG_HI] = 1'b1;
        mag1 = mag0 - st0;
      end
      mag2 = mag1;
      if (mag1 >= st1) begin
        code[1] = 1'b1;
        mag2 = mag1 - st1;
      end
      if (mag2 >= st2) code[0] = 1'b1;
    end else begin
      code = s1_code;
    end

    vpdiff = (st0 >> 3)
           + (code[0] ? st2 : '0)
           + (code[1] ? st1 : '0)
           + (code[CODE_MAG_HI] ? st0 : '0);

    if (code[CODE_SIGN]) begin
      pred_sum = {{2{pred_cur[PCM_W-1]}}, pred_cur} - $signed({1'b0, vpdiff});
    end else begin
      pred_sum = {{2{pred_cur[PCM_W-1]}}, pred_cur} + $signed({1'b0, vpdiff});
    end
    if (pred_sum < PCM_MIN) begin
      pred_next = PCM_MIN[PCM_W-1:0];
    end else if (pred_sum > PCM_MAX) begin
      pred_next = PCM_MAX[PCM_W-1:0];
    end else begin
      pred_next = pred_sum[PCM_W-1:0];
    end

    idx_sum = $signed({2'b00, idx_cur}) + (IDX_W+2)'(index_adjust(code[2:0]));
    if (idx_sum < 0) begin
      idx_next = '0;
    end else if (idx_sum > $signed((IDX_W+2)'(IDX_MAX))) begin
      idx_next = IDX_W'(IDX_MAX);
    end else begin
      idx_next = idx_sum[IDX_W-1:0];
    end
  end

  // Configuration writes; indexes beyond the list drop
  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode  <= 1'b0;
      restart_pred <= '0;
      restart_idx  <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_ENCODE_MODE:  encode_mode  <= cfg_ch.data[0];
        CFG_RESTART_PRED: restart_pred <= cfg_ch.data;
        CFG_RESTART_IDX:  restart_idx  <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      predictor <= '0;
      index     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        predictor <= pred_next;
        index     <= idx_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_restart <= in_ch.restart;
      s1_pcm     <= in_ch.pcm_in;
      s1_code    <= in_ch.code_in;
    end
    if (s1_adv) begin
      out_code  <= code;
      out_pcm   <= pred_next;
      out_index <= idx_next;
    end
  end

  // Assertions
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    index <= IDX_W'(IDX_MAX))
    else $error("step index left 0..88");

  a_out_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_index <= IDX_W'(IDX_MAX))
    else $error("result step index out of range");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_valid && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_state_matches_result: assert property (@(posedge clk) disable iff (rst)
    $past(s1_adv) && !$past(rst) |-> (predictor == out_pcm) && (index == out_index))
    else $error("state and result register disagree");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_pcm) && $stable(s1_code))
    else $error("held item lost in input register");

endmodule
